FILE: hw/rtl/assert_macros.svh
// assertion macros included by fly_camera_view_matrix.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fcvm_pkg.sv
// types, constants and the arctangent table of the fly camera view block
package fcvm_pkg;

    localparam int VEC_FRAC      = 14;
    localparam int ANG_FRAC      = 8;
    localparam int CORDIC_FRAC   = 30;
    localparam int CORDIC_STEPS  = 16;
    localparam int TABLE_LEN     = 24;
    localparam int ANG_SHIFT     = 16 - ANG_FRAC;
    localparam int CORDIC_DROP   = CORDIC_FRAC - VEC_FRAC;

    localparam int ANG_FULL      = 360 << ANG_FRAC;
    localparam int ANG_HALF      = 180 << ANG_FRAC;
    localparam int ANG_QUARTER   = 90 << ANG_FRAC;
    localparam int PITCH_LIMIT   = 89 << ANG_FRAC;
    localparam int ZOOM_MIN      = 1 << ANG_FRAC;
    localparam int ZOOM_MAX      = 45 << ANG_FRAC;
    localparam int YAW_RESET     = 270 << ANG_FRAC;
    localparam int SPEED_RESET   = 640;
    localparam int VEC_ONE       = 1 << VEC_FRAC;
    localparam longint CORDIC_GAIN = 652032874;

    typedef enum logic [1:0] {
        ACT_LOOK = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_ZOOM = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        DIR_NONE     = 3'd0,
        DIR_FORWARD  = 3'd1,
        DIR_BACKWARD = 3'd2,
        DIR_LEFT     = 3'd3,
        DIR_RIGHT    = 3'd4,
        DIR_UP       = 3'd5,
        DIR_DOWN     = 3'd6
    } t_dir;

    typedef enum logic [1:0] {
        CFG_START_X    = 2'd0,
        CFG_START_Y    = 2'd1,
        CFG_START_Z    = 2'd2,
        CFG_MOVE_SPEED = 2'd3
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOAD,
        S_CITER,
        S_CSTORE,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    // atan(2^-i) in degrees with 16 fraction bits
    function automatic logic [21:0] atan_deg(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/fly_camera_view_matrix.sv
// fly camera: euler-angle state, cordic basis and view translation
//
// Usage: events enter on the s_axis channel (tuser holds the action, tdata the
// deltas, move direction and time step). Each accepted transaction updates
// yaw, pitch, position or zoom and yields exactly one transaction on m_axis:
// right, up and front vectors in Q2.14, the view translation in Q16.16
// (saturated) and the current zoom in Q8.8 degrees.
// m_axis_tvalid rises after two passes of the shared cordic rotator (yaw, then
// pitch) followed by seventeen operations on one 17 x 33 multiplier, each a
// multiply state and an accumulate state. s_axis_tready is high only when idle,
// so one event is in flight at a time and a new event is taken only after the
// result has been taken.
// If the receiver stalls, the result is held on m_axis until taken and no new
// event is accepted. Reset sets yaw to 270, pitch to 0, zoom to 45 degrees,
// speed to 2.5 and the start position and eye to zero. The configuration port
// writes start_x/y/z (also loading the eye coordinate) and move_speed; write it
// only while the block is idle.
`include "assert_macros.svh"

module fly_camera_view_matrix #(
    parameter int CORDIC_STEPS = fcvm_pkg::CORDIC_STEPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // delta_x[16:0], delta_y[33:17], move_dir[36:34], time_step[52:37]
    input  logic [55:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // right_x, right_z, up_x, up_y, up_z, front_x, front_y, front_z (16 each),
    // shift_x, shift_y, shift_z (32 each), zoom_angle[240:224]
    output logic [247:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import fcvm_pkg::*;

    localparam int IT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic [4:0] OP_F0   = 5'd0;
    localparam logic [4:0] OP_F2   = 5'd1;
    localparam logic [4:0] OP_U0   = 5'd2;
    localparam logic [4:0] OP_U2   = 5'd3;
    localparam logic [4:0] OP_VEL  = 5'd4;
    localparam logic [4:0] OP_MV0  = 5'd5;
    localparam logic [4:0] OP_DOT0 = 5'd8;
    localparam logic [4:0] OP_LAST = 5'd16;

    t_state r_state, n_state;

    // architectural state
    logic [16:0]        r_yaw;
    logic signed [15:0] r_pitch;
    logic signed [17:0] r_zoom;
    logic signed [31:0] r_ex, r_ey, r_ez;
    logic [15:0]        r_speed;

    // captured event
    t_action            r_act;
    t_dir               r_dir;
    logic [15:0]        r_ts;

    // cordic rotator
    logic                r_csel;
    logic [IT_W-1:0]     r_it;
    logic signed [32:0]  r_cx, r_cy;
    logic signed [26:0]  r_cz;
    logic                r_cneg;

    // basis and results
    logic signed [15:0] r_sy, r_cyw, r_sp, r_cp;
    logic signed [15:0] r_f0, r_f2, r_u0, r_u2;
    logic [31:0]        r_vel;
    logic signed [51:0] r_acc;
    logic signed [31:0] r_shx, r_shy, r_shz;
    logic [4:0]         r_op;
    logic signed [49:0] r_prod;

    // input fields
    logic signed [16:0] w_dx, w_dy;
    assign w_dx = s_axis_tdata[16:0];
    assign w_dy = s_axis_tdata[33:17];

    logic w_acc_in;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_acc_in) n_state = S_CLOAD;
            S_CLOAD:  n_state = S_CITER;
            S_CITER:  if (r_it == IT_W'(CORDIC_STEPS - 1)) n_state = S_CSTORE;
            S_CSTORE: n_state = r_csel ? S_MUL : S_CLOAD;
            S_MUL:    n_state = S_ACC;
            S_ACC:    n_state = (r_op == OP_LAST) ? S_OUT : S_MUL;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- handshake outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_OUT:   m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    // ---------------- look and zoom update ----------------
    logic signed [18:0] w_yaw_sum, w_yaw_new;
    logic signed [17:0] w_pitch_sum;
    logic signed [16:0] w_pitch_new;
    logic signed [17:0] w_zoom_new;
    always_comb begin
        w_yaw_sum = $signed({2'b00, r_yaw}) + 19'(w_dx);
        if (w_yaw_sum < 0)
            w_yaw_new = w_yaw_sum + 19'(ANG_FULL);
        else if (w_yaw_sum >= 19'(ANG_FULL))
            w_yaw_new = w_yaw_sum - 19'(ANG_FULL);
        else
            w_yaw_new = w_yaw_sum;
        w_pitch_sum = 18'(r_pitch) + 18'(w_dy);
        if (w_pitch_sum > 18'(PITCH_LIMIT))
            w_pitch_new = 17'(PITCH_LIMIT);
        else if (w_pitch_sum < -18'(PITCH_LIMIT))
            w_pitch_new = -17'(PITCH_LIMIT);
        else
            w_pitch_new = 17'(w_pitch_sum);
        // an out-of-range zoom is clamped now and the delta of this event is dropped
        if (r_zoom >= 18'(ZOOM_MIN) && r_zoom <= 18'(ZOOM_MAX))
            w_zoom_new = r_zoom - 18'(w_dy);
        else if (r_zoom < 18'(ZOOM_MIN))
            w_zoom_new = 18'(ZOOM_MIN);
        else
            w_zoom_new = 18'(ZOOM_MAX);
    end

    // ---------------- cordic ----------------
    logic signed [17:0] w_ang, w_a1;
    logic signed [17:0] w_afold;
    logic               w_fneg;
    logic signed [32:0] w_xs, w_ys;
    logic signed [26:0] w_atan;
    logic signed [16:0] w_xr, w_yr;
    logic signed [15:0] w_xc, w_yc, w_cos, w_sin;
    always_comb begin
        w_ang = r_csel ? 18'(r_pitch) : $signed({1'b0, r_yaw});
        w_a1 = (w_ang >= 18'(ANG_HALF)) ? w_ang - 18'(ANG_FULL) : w_ang;
        w_fneg = 1'b0;
        w_afold = w_a1;
        if (w_a1 > 18'(ANG_QUARTER)) begin
            w_afold = w_a1 - 18'(ANG_HALF);
            w_fneg = 1'b1;
        end else if (w_a1 < -18'(ANG_QUARTER)) begin
            w_afold = w_a1 + 18'(ANG_HALF);
            w_fneg = 1'b1;
        end
        w_xs = r_cx >>> r_it;
        w_ys = r_cy >>> r_it;
        w_atan = $signed({5'b0, atan_deg(5'(r_it))});
        w_xr = 17'((r_cx + 33'sd32768) >>> CORDIC_DROP);
        w_yr = 17'((r_cy + 33'sd32768) >>> CORDIC_DROP);
        w_xc = (w_xr > 17'(VEC_ONE)) ? 16'(VEC_ONE) :
               (w_xr < -17'(VEC_ONE)) ? -16'(VEC_ONE) : 16'(w_xr);
        w_yc = (w_yr > 17'(VEC_ONE)) ? 16'(VEC_ONE) :
               (w_yr < -17'(VEC_ONE)) ? -16'(VEC_ONE) : 16'(w_yr);
        w_cos = r_cneg ? -w_xc : w_xc;
        w_sin = r_cneg ? -w_yc : w_yc;
    end

    // ---------------- shared multiplier operands ----------------
    logic signed [15:0] w_rx, w_rz, w_ux, w_uy, w_uz, w_fx, w_fy, w_fz;
    assign w_rx = -r_sy;
    assign w_rz = r_cyw;
    assign w_ux = r_u0;
    assign w_uy = r_cp;
    assign w_uz = r_u2;
    assign w_fx = r_f0;
    assign w_fy = r_sp;
    assign w_fz = r_f2;

    // move vector and direction
    logic signed [15:0] w_mv0, w_mv1, w_mv2;
    logic               w_msub;
    always_comb begin
        w_mv0 = '0;
        w_mv1 = '0;
        w_mv2 = '0;
        w_msub = 1'b0;
        if (r_act == ACT_MOVE) begin
            case (r_dir)
                DIR_FORWARD, DIR_BACKWARD: begin
                    w_mv0 = w_fx;
                    w_mv1 = w_fy;
                    w_mv2 = w_fz;
                end
                DIR_LEFT, DIR_RIGHT: begin
                    w_mv0 = w_rx;
                    w_mv2 = w_rz;
                end
                DIR_UP, DIR_DOWN: w_mv1 = 16'(VEC_ONE);
                default: ;
            endcase
            w_msub = (r_dir == DIR_BACKWARD) || (r_dir == DIR_LEFT) || (r_dir == DIR_DOWN);
        end
    end

    logic [1:0]         w_k;
    logic [1:0]         w_vsel;
    logic [4:0]         w_dot_op;
    logic [1:0]         w_dot_rem;
    logic signed [16:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [31:0] w_eye_k;
    logic signed [15:0] w_vec_k, w_mv_k;
    always_comb begin
        w_dot_op = r_op - OP_DOT0;
        // dot index split into vector and coordinate by compare and subtract
        if (w_dot_op >= 5'd6) begin
            w_vsel = 2'd2;
            w_dot_rem = 2'(w_dot_op - 5'd6);
        end else if (w_dot_op >= 5'd3) begin
            w_vsel = 2'd1;
            w_dot_rem = 2'(w_dot_op - 5'd3);
        end else begin
            w_vsel = 2'd0;
            w_dot_rem = 2'(w_dot_op);
        end
        w_k = (r_op >= OP_DOT0) ? w_dot_rem : 2'(r_op - OP_MV0);
        case (w_k)
            2'd0:    w_eye_k = r_ex;
            2'd1:    w_eye_k = r_ey;
            default: w_eye_k = r_ez;
        endcase
        case (w_k)
            2'd0:    w_mv_k = w_mv0;
            2'd1:    w_mv_k = w_mv1;
            default: w_mv_k = w_mv2;
        endcase
        case ({w_vsel, w_k})
            4'b00_00: w_vec_k = w_rx;
            4'b00_10: w_vec_k = w_rz;
            4'b01_00: w_vec_k = w_ux;
            4'b01_01: w_vec_k = w_uy;
            4'b01_10: w_vec_k = w_uz;
            4'b10_00: w_vec_k = w_fx;
            4'b10_01: w_vec_k = w_fy;
            4'b10_10: w_vec_k = w_fz;
            default:  w_vec_k = '0;
        endcase
        case (r_op)
            OP_F0: begin
                w_ma = 17'(r_cyw);
                w_mb = 33'(r_cp);
            end
            OP_F2: begin
                w_ma = 17'(r_sy);
                w_mb = 33'(r_cp);
            end
            OP_U0: begin
                w_ma = 17'(r_cyw);
                w_mb = 33'(r_sp);
            end
            OP_U2: begin
                w_ma = 17'(r_sy);
                w_mb = 33'(r_sp);
            end
            OP_VEL: begin
                w_ma = $signed({1'b0, r_ts});
                w_mb = $signed({17'b0, r_speed});
            end
            default: begin
                if (r_op < OP_DOT0) begin
                    w_ma = 17'(w_mv_k);
                    w_mb = $signed({1'b0, r_vel});
                end else begin
                    w_ma = 17'(w_vec_k);
                    w_mb = 33'(w_eye_k);
                end
            end
        endcase
    end

    // ---------------- consuming the product ----------------
    logic signed [15:0] w_rs14;
    logic signed [27:0] w_step;
    logic signed [32:0] w_mov_sum;
    logic signed [31:0] w_mov_sat;
    logic signed [51:0] w_acc_new, w_dot_v;
    logic signed [37:0] w_dot_r;
    logic signed [31:0] w_dot_sat;
    always_comb begin
        w_rs14 = 16'((r_prod + 50'sd8192) >>> VEC_FRAC);
        w_step = 28'((r_prod + 50'sd2097152) >>> (VEC_FRAC + 8));
        w_mov_sum = w_msub ? 33'(w_eye_k) - 33'(w_step) : 33'(w_eye_k) + 33'(w_step);
        w_mov_sat = (w_mov_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                    (w_mov_sum < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(w_mov_sum);
        w_acc_new = (w_k == 2'd0) ? 52'(r_prod) : r_acc + 52'(r_prod);
        w_dot_v = (w_vsel == 2'd2) ? w_acc_new : -w_acc_new;
        w_dot_r = 38'((w_dot_v + 52'sd8192) >>> VEC_FRAC);
        w_dot_sat = (w_dot_r > 38'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                    (w_dot_r < -38'sh8000_0000) ? 32'sh8000_0000 : 32'(w_dot_r);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_yaw   <= 17'(YAW_RESET);
            r_pitch <= '0;
            r_zoom  <= 18'(ZOOM_MAX);
            r_ex    <= '0;
            r_ey    <= '0;
            r_ez    <= '0;
            r_speed <= 16'(SPEED_RESET);
            r_csel  <= 1'b0;
            r_it    <= '0;
            r_op    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg'(i_cfg_idx))
                    CFG_START_X:    r_ex <= i_cfg_data;
                    CFG_START_Y:    r_ey <= i_cfg_data;
                    CFG_START_Z:    r_ez <= i_cfg_data;
                    CFG_MOVE_SPEED: r_speed <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_act  <= t_action'(s_axis_tuser);
                        r_dir  <= t_dir'(s_axis_tdata[36:34]);
                        r_ts   <= s_axis_tdata[52:37];
                        r_csel <= 1'b0;
                        if (t_action'(s_axis_tuser) == ACT_LOOK) begin
                            r_yaw   <= 17'(w_yaw_new);
                            r_pitch <= 16'(w_pitch_new);
                        end else if (t_action'(s_axis_tuser) == ACT_ZOOM) begin
                            r_zoom <= w_zoom_new;
                        end
                    end
                end
                S_CLOAD: begin
                    r_cx   <= 33'(CORDIC_GAIN);
                    r_cy   <= '0;
                    r_cz   <= 27'(w_afold) <<< ANG_SHIFT;
                    r_cneg <= w_fneg;
                    r_it   <= '0;
                end
                S_CITER: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + w_atan;
                    end
                    r_it <= r_it + 1'b1;
                end
                S_CSTORE: begin
                    if (r_csel) begin
                        r_sp <= w_sin;
                        r_cp <= w_cos;
                    end else begin
                        r_sy  <= w_sin;
                        r_cyw <= w_cos;
                    end
                    r_csel <= 1'b1;
                    r_op   <= '0;
                end
                S_MUL: r_prod <= w_ma * w_mb;
                S_ACC: begin
                    case (r_op)
                        OP_F0:  r_f0  <= w_rs14;
                        OP_F2:  r_f2  <= w_rs14;
                        OP_U0:  r_u0  <= -w_rs14;
                        OP_U2:  r_u2  <= -w_rs14;
                        OP_VEL: r_vel <= r_prod[31:0];
                        default: begin
                            if (r_op < OP_DOT0) begin
                                case (w_k)
                                    2'd0:    r_ex <= w_mov_sat;
                                    2'd1:    r_ey <= w_mov_sat;
                                    default: r_ez <= w_mov_sat;
                                endcase
                            end else begin
                                r_acc <= w_acc_new;
                                if (w_k == 2'd2) begin
                                    case (w_vsel)
                                        2'd0:    r_shx <= w_dot_sat;
                                        2'd1:    r_shy <= w_dot_sat;
                                        default: r_shz <= w_dot_sat;
                                    endcase
                                end
                            end
                        end
                    endcase
                    r_op <= r_op + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- result ----------------
    logic signed [16:0] w_zoom_out;
    assign w_zoom_out = (r_zoom > 18'sd65535) ? 17'sd65535 :
                        (r_zoom < -18'sd65536) ? -17'sd65536 : 17'(r_zoom);

    assign m_axis_tdata = {7'b0, w_zoom_out, r_shz, r_shy, r_shx,
                           w_fz, w_fy, w_fx, w_uz, w_uy, w_ux, w_rz, w_rx};

    `ASSERT_CLK(a_pitch_range,
        r_pitch <= 16'(PITCH_LIMIT) && r_pitch >= -16'(PITCH_LIMIT),
        "pitch left its clamp range")
    `ASSERT_CLK(a_yaw_range, r_yaw < 17'(ANG_FULL), "yaw not wrapped")
    `ASSERT_IMP(a_busy_no_ready, r_state != S_IDLE, !s_axis_tready,
        "ready while an event is in flight")
    `ASSERT_IMP(a_out_stall_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid,
        "result dropped under stall")

endmodule
